[rtl/qgci_pkg.sv]
// ----------------------------------------------------------------------------
// qgci_pkg: shared types and constants for the quotient grid cell index block
// Topology codes, the flag decode and the request sideband layout.
// ----------------------------------------------------------------------------
package qgci_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_MODE   = 4'd0;
  localparam logic [3:0] CFG_COUNT  = 4'd1;
  localparam logic [3:0] CFG_WIDTH  = 4'd2;
  localparam logic [3:0] CFG_HEIGHT = 4'd3;

  // Topology codes that carry flags; every other code is a plain torus
  localparam logic [3:0] TOPO_ROW_A     = 4'd0;
  localparam logic [3:0] TOPO_ROW_B     = 4'd1;
  localparam logic [3:0] TOPO_HEX       = 4'd4;
  localparam logic [3:0] TOPO_KLEIN_A   = 4'd5;
  localparam logic [3:0] TOPO_KLEIN_HEX = 4'd6;
  localparam logic [3:0] TOPO_KLEIN_B   = 4'd9;
  localparam logic [3:0] TOPO_KLEIN_C   = 4'd10;

  // Plain torus codes
  localparam logic [3:0] TOPO_PLAIN_A = 4'd2;
  localparam logic [3:0] TOPO_PLAIN_B = 4'd3;
  localparam logic [3:0] TOPO_PLAIN_C = 4'd7;
  localparam logic [3:0] TOPO_PLAIN_D = 4'd8;

  // Reset values of the configuration registers
  localparam logic [3:0]  RST_MODE   = TOPO_ROW_A;
  localparam logic [15:0] RST_COUNT  = 16'd381;
  localparam logic [7:0]  RST_WIDTH  = 8'd12;
  localparam logic [7:0]  RST_HEIGHT = 8'd12;

  // ceil(2^19 / 3): exact quotient by three for magnitudes below 2^19
  localparam logic [17:0] RECIP3       = 18'd174763;
  localparam int unsigned RECIP3_SHIFT = 19;

  typedef struct packed {
    logic single;
    logic klein;
    logic weird;
  } topo_flags_t;

  // Sideband carried through the first remainder unit
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [17:0] y;
  } unpack_side_t;

  function automatic topo_flags_t mode_flags(input logic [3:0] mode);
    topo_flags_t f;
    f = '0;
    case (mode)
      TOPO_ROW_A, TOPO_ROW_B:                   f.single = 1'b1;
      TOPO_HEX:                                 f.weird  = 1'b1;
      TOPO_KLEIN_A, TOPO_KLEIN_B, TOPO_KLEIN_C: f.klein  = 1'b1;
      TOPO_KLEIN_HEX: begin
        f.klein = 1'b1;
        f.weird = 1'b1;
      end
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

[rtl/quotient_grid_cell_index_top.sv]
// ----------------------------------------------------------------------------
// quotient_grid_cell_index_top: packed grid vector to wrapped cell index
// Throughput one request per cycle; the whole pipeline holds while the
// output register is full and not taken, so ready follows the output side.
// Depth is set by the two remainder units (8 and 5 stages, 4 bits each).
// Reset clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
module quotient_grid_cell_index_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] packed_vector_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        cell_index_o,
  output logic               mirrored_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import qgci_pkg::*;

  logic [3:0]  mode_q;
  logic [15:0] count_q;
  logic [7:0]  width_q;
  logic [7:0]  height_q;
  logic [7:0]  w_eff;
  logic [7:0]  h_eff;
  topo_flags_t fl;
  logic        en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_MODE;
      count_q  <= RST_COUNT;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[3:0];
        CFG_COUNT:  count_q  <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i[7:0];
        CFG_HEIGHT: height_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q == 8'd0) ? 8'd1 : width_q;
  assign h_eff = (height_q == 8'd0) ? 8'd1 : height_q;
  assign fl    = mode_flags(mode_q);

  logic        out_vld_q;
  logic [15:0] out_idx_q;
  logic        out_mir_q;

  // Advance everything whenever the output register can take a result
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: capture the request
  logic               s0_vld_q;
  logic signed [31:0] s0_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else if (en) s0_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) s0_vec_q <= packed_vector_i;
  end

  // Unpack and set up the first remainder (row modulus or Klein fold)
  logic signed [15:0] x0;
  logic signed [17:0] y0;
  logic [31:0]        d1_dvd;
  logic [15:0]        d1_dsr;
  logic               d1_neg;
  unpack_side_t       d1_side;

  always_comb begin
    logic [15:0] xabs;
    x0   = signed'({s0_vec_q[14], s0_vec_q[14:0]});
    y0   = signed'({s0_vec_q[31], s0_vec_q[31:15]} + {17'd0, s0_vec_q[14]});
    xabs = x0[15] ? 16'(-x0) : 16'(x0);
    if (fl.single) begin
      d1_dvd = s0_vec_q[31] ? 32'(-s0_vec_q) : 32'(s0_vec_q);
      d1_dsr = count_q;
      d1_neg = s0_vec_q[31];
    end else if (fl.klein) begin
      d1_dvd = {16'd0, xabs};
      d1_dsr = fl.weird ? {6'd0, w_eff, 2'b00} : {7'd0, w_eff, 1'b0};
      d1_neg = x0[15];
    end else begin
      d1_dvd = '0;
      d1_dsr = 16'd1;
      d1_neg = 1'b0;
    end
    d1_side.x = x0;
    d1_side.y = y0;
  end

  logic         r1_vld;
  logic [15:0]  r1_rem;
  logic [15:0]  r1_dsr;
  logic         r1_neg;
  unpack_side_t r1_side;

  qgci_rem #(
    .DW (32),
    .MW (16),
    .BPS(4),
    .PW ($bits(unpack_side_t))
  ) u_rem_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s0_vld_q),
    .dvd_i  (d1_dvd),
    .dsr_i  (d1_dsr),
    .neg_i  (d1_neg),
    .side_i (d1_side),
    .valid_o(r1_vld),
    .rem_o  (r1_rem),
    .dsr_o  (r1_dsr),
    .neg_o  (r1_neg),
    .side_o (r1_side)
  );

  // Stage 1: fix the remainder sign, fold and mirror
  logic               s1_vld_q;
  logic signed [15:0] s1_x_q;
  logic signed [17:0] s1_y_q;
  logic               s1_mir_q;
  logic [15:0]        s1_idx_q;
  logic signed [15:0] s1_x_d;
  logic signed [17:0] s1_y_d;
  logic               s1_mir_d;
  logic [15:0]        s1_idx_d;

  always_comb begin
    logic [15:0] rc;
    rc       = (r1_neg && r1_rem != 16'd0) ? 16'(r1_dsr - r1_rem) : r1_rem;
    s1_idx_d = (count_q == 16'd0) ? 16'd0 : rc;
    s1_mir_d = 1'b0;
    if (fl.klein) begin
      if (fl.weird) s1_mir_d = (rc != 16'd0) && (rc <= {7'd0, w_eff, 1'b0});
      else          s1_mir_d = (rc >= {8'd0, w_eff});
    end
    s1_x_d = fl.klein ? signed'(rc) : r1_side.x;
    s1_y_d = s1_mir_d ? 18'(-r1_side.y) : r1_side.y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= r1_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q   <= s1_x_d;
      s1_y_q   <= s1_y_d;
      s1_mir_q <= s1_mir_d;
      s1_idx_q <= s1_idx_d;
    end
  end

  // Stage 2: in the hex modes, y divided by three, truncating toward zero
  logic               s2_vld_q;
  logic signed [15:0] s2_x_q;
  logic signed [17:0] s2_y_q;
  logic               s2_mir_q;
  logic [15:0]        s2_idx_q;
  logic signed [17:0] s2_y_d;

  always_comb begin
    logic [16:0] yabs;
    logic [34:0] prod;
    logic [15:0] q;
    yabs = s1_y_q[17] ? 17'(-s1_y_q) : s1_y_q[16:0];
    prod = 35'(yabs) * 35'(RECIP3);
    q    = prod[RECIP3_SHIFT +: 16];
    if (fl.weird) s2_y_d = s1_y_q[17] ? 18'(-{2'b00, q}) : {2'b00, q};
    else          s2_y_d = s1_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (en) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s2_y_d;
      s2_mir_q <= s1_mir_q;
      s2_idx_q <= s1_idx_q;
    end
  end

  // Stage 3: in the hex modes, x plus the parity of y divided by minus two; split off signs
  logic        s3_vld_q;
  logic [16:0] s3_xabs_q;
  logic        s3_xneg_q;
  logic [16:0] s3_yabs_q;
  logic        s3_yneg_q;
  logic        s3_mir_q;
  logic [15:0] s3_idx_q;
  logic [16:0] s3_xabs_d;
  logic        s3_xneg_d;

  always_comb begin
    logic signed [16:0] t;
    logic signed [16:0] xn;
    t = 17'(s2_x_q) + {16'd0, s2_y_q[0]};
    if (fl.weird) begin
      if (t[16]) xn = signed'(17'(-t) >> 1);
      else       xn = 17'(-(t >>> 1));
    end else begin
      xn = 17'(s2_x_q);
    end
    s3_xneg_d = xn[16];
    s3_xabs_d = xn[16] ? 17'(-xn) : 17'(xn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (en) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_xabs_q <= s3_xabs_d;
      s3_xneg_q <= s3_xneg_d;
      s3_yabs_q <= s2_y_q[17] ? 17'(-s2_y_q) : s2_y_q[16:0];
      s3_yneg_q <= s2_y_q[17];
      s3_mir_q  <= s2_mir_q;
      s3_idx_q  <= s2_idx_q;
    end
  end

  // Wrap x by the width and y by the height side by side
  logic        rx_vld;
  logic [7:0]  rx_rem;
  logic [7:0]  rx_dsr;
  logic        rx_neg;
  logic [15:0] rx_idx;
  logic        ry_vld;
  logic [7:0]  ry_rem;
  logic [7:0]  ry_dsr;
  logic        ry_neg;
  logic        ry_mir;

  qgci_rem #(
    .DW (20),
    .MW (8),
    .BPS(4),
    .PW (16)
  ) u_rem_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s3_vld_q),
    .dvd_i  ({3'b000, s3_xabs_q}),
    .dsr_i  (w_eff),
    .neg_i  (s3_xneg_q),
    .side_i (s3_idx_q),
    .valid_o(rx_vld),
    .rem_o  (rx_rem),
    .dsr_o  (rx_dsr),
    .neg_o  (rx_neg),
    .side_o (rx_idx)
  );

  qgci_rem #(
    .DW (20),
    .MW (8),
    .BPS(4),
    .PW (1)
  ) u_rem_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s3_vld_q),
    .dvd_i  ({3'b000, s3_yabs_q}),
    .dsr_i  (h_eff),
    .neg_i  (s3_yneg_q),
    .side_i (s3_mir_q),
    .valid_o(ry_vld),
    .rem_o  (ry_rem),
    .dsr_o  (ry_dsr),
    .neg_o  (ry_neg),
    .side_o (ry_mir)
  );

  // Output stage: row-major index, or the row remainder in the row modes
  logic [15:0] out_idx_d;

  always_comb begin
    logic [7:0] xm;
    logic [7:0] ym;
    xm = (rx_neg && rx_rem != 8'd0) ? 8'(rx_dsr - rx_rem) : rx_rem;
    ym = (ry_neg && ry_rem != 8'd0) ? 8'(ry_dsr - ry_rem) : ry_rem;
    if (fl.single) out_idx_d = rx_idx;
    else           out_idx_d = 16'(16'(ym) * 16'(rx_dsr)) + {8'd0, xm};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= rx_vld && ry_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_idx_q <= out_idx_d;
      out_mir_q <= ry_mir;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cell_index_o = out_idx_q;
  assign mirrored_o   = out_mir_q;

endmodule

[rtl/qgci_rem.sv]
// ----------------------------------------------------------------------------
// qgci_rem: pipelined unsigned remainder unit
// Restoring division, BPS quotient bits per stage, remainder only; the sign
// flag, divisor and sideband ride along with each request.
// ----------------------------------------------------------------------------
module qgci_rem #(
  parameter int unsigned DW  = 32,
  parameter int unsigned MW  = 16,
  parameter int unsigned BPS = 4,
  parameter int unsigned PW  = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [MW-1:0] dsr_i,
  input  logic          neg_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [MW-1:0] rem_o,
  output logic [MW-1:0] dsr_o,
  output logic          neg_o,
  output logic [PW-1:0] side_o
);

  localparam int unsigned NS = DW / BPS;

  logic          vld_q  [NS];
  logic [MW-1:0] rem_q  [NS];
  logic [DW-1:0] dvd_q  [NS];
  logic [MW-1:0] dsr_q  [NS];
  logic          neg_q  [NS];
  logic [PW-1:0] side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          vld_in;
    logic [MW-1:0] rem_in;
    logic [DW-1:0] dvd_in;
    logic [MW-1:0] dsr_in;
    logic          neg_in;
    logic [PW-1:0] side_in;
    logic [MW-1:0] rem_d;
    logic [DW-1:0] dvd_d;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign dvd_in  = dvd_i;
      assign dsr_in  = dsr_i;
      assign neg_in  = neg_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign dvd_in  = dvd_q[s-1];
      assign dsr_in  = dsr_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin : p_steps
      logic [MW:0]   t;
      logic [MW-1:0] r;
      logic [DW-1:0] a;
      r = rem_in;
      a = dvd_in;
      t = '0;
      for (int k = 0; k < BPS; k++) begin
        t = {r, a[DW-1]};
        a = {a[DW-2:0], 1'b0};
        if (t >= {1'b0, dsr_in}) t = t - {1'b0, dsr_in};
        r = t[MW-1:0];
      end
      rem_d = r;
      dvd_d = a;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        dvd_q[s]  <= dvd_d;
        dsr_q[s]  <= dsr_in;
        neg_q[s]  <= neg_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign rem_o   = rem_q[NS-1];
  assign dsr_o   = dsr_q[NS-1];
  assign neg_o   = neg_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

[rtl/qgci_checker.sv]
// ----------------------------------------------------------------------------
// qgci_checker: port-level checks for the quotient grid cell index block
// Watches the handshakes and the stall coupling of the top level.
// ----------------------------------------------------------------------------
module qgci_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [31:0] packed_vector_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [15:0]        cell_index_o,
  input logic               mirrored_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cell_index_o) && $stable(mirrored_o))
    else $error("result changed while stalled");

  // A waiting request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(packed_vector_i))
    else $error("request changed while waiting");

  // The input side advances exactly when the output register frees up
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready not tied to output progress");

  a_rst_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

endmodule

bind quotient_grid_cell_index_top qgci_checker u_qgci_checker (.*);

[bench/quotient_grid_cell_index_top_tb.sv]
// ----------------------------------------------------------------------------
// quotient_grid_cell_index_top_tb: cell index and mirror check
// Walks a short table of vectors across the topologies, then streams random
// vectors under a series of register settings. Every result is compared with
// a table value or a local model of the index arithmetic, under bursty requests and stalls.
// ----------------------------------------------------------------------------
module quotient_grid_cell_index_top_tb;
  import qgci_pkg::*;

  typedef struct {
    logic [15:0] idx;
    logic        mirror;
  } cell_result_t;

  typedef struct {
    logic [3:0]         mode;
    logic signed [31:0] vec;
    bit                 known;
    logic [15:0]        idx;
    logic               mirror;
  } vector_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] packed_vector_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        cell_index_o;
  logic               mirrored_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [3:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  quotient_grid_cell_index_top uut (.*);

  // Register copies for the local model
  logic [3:0]  topo_mode;
  logic [15:0] row_count;
  logic [7:0]  grid_w;
  logic [7:0]  grid_h;

  cell_result_t pending_cells[$];
  int unsigned  mismatches;
  int unsigned  burst_left;
  int unsigned  stall_kind;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  function automatic longint floor_mod(longint a, longint m);
    longint r;
    r = a % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic cell_result_t predict_cell(logic signed [31:0] vec);
    cell_result_t res;
    longint v, x, y, w, h;
    bit single, klein, weird, mir;
    v = vec;
    single = (topo_mode == TOPO_ROW_A) || (topo_mode == TOPO_ROW_B);
    klein  = (topo_mode == TOPO_KLEIN_A) || (topo_mode == TOPO_KLEIN_B) ||
             (topo_mode == TOPO_KLEIN_C) || (topo_mode == TOPO_KLEIN_HEX);
    weird  = (topo_mode == TOPO_HEX) || (topo_mode == TOPO_KLEIN_HEX);
    w = (grid_w == 0) ? 1 : grid_w;
    h = (grid_h == 0) ? 1 : grid_h;
    mir = 1'b0;
    if (single) begin
      res.idx    = (row_count == 0) ? 16'd0 : 16'(floor_mod(v, row_count));
      res.mirror = 1'b0;
      return res;
    end
    x = vec[14:0];
    y = (v - x) / 32768;
    if (x >= (1 << 14)) begin
      x -= (1 << 15);
      y += 1;
    end
    if (klein) begin
      if (weird) begin
        x = floor_mod(x, 4 * w);
        mir = (x > 0) && (x <= 2 * w);
      end else begin
        x = floor_mod(x, 2 * w);
        mir = (x >= w);
      end
      if (mir) y = -y;
    end
    if (weird) begin
      y = y / 3;
      x = (x + (y & 1)) / -2;
    end
    x = floor_mod(x, w);
    y = floor_mod(y, h);
    res.idx    = 16'(y * w + x);
    res.mirror = mir;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Drain the pipeline, then write one register
  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    wait (pending_cells.size() == 0);
    repeat (24) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:   topo_mode = data[3:0];
      CFG_COUNT:  row_count = data;
      CFG_WIDTH:  grid_w    = data[7:0];
      CFG_HEIGHT: grid_h    = data[7:0];
      default: ;
    endcase
  endtask

  // Present one request; hold valid across a burst, drop it for a gap after
  task automatic send_vector(logic signed [31:0] vec, bit known, cell_result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      if (in_valid_i) begin
        in_valid_i <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_valid_i      <= 1'b1;
    packed_vector_i <= vec;
    do @(posedge clk_i); while (!in_ready_o);
    pending_cells.push_back(known ? want : predict_cell(vec));
    burst_left--;
  endtask

  task automatic idle_sender();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] random_vector();
    int signed xs, ys;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        xs = $urandom_range(0, 80) - 40;
        ys = $urandom_range(0, 80) - 40;
        return xs + (ys <<< 15);
      end
      2: return 32'($urandom_range(16376, 16392)) + ($urandom_range(0, 6) - 3) * 32768;
      default: begin
        xs = $urandom_range(0, 32767) - 16384;
        ys = $urandom_range(0, 65535) - 32768;
        return xs + (ys <<< 15);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected result", cell_index_o, -1);
      end else begin
        want = pending_cells.pop_front();
        if (cell_index_o !== want.idx) report_mismatch("cell_index", cell_index_o, want.idx);
        if (mirrored_o !== want.mirror) report_mismatch("mirrored", mirrored_o, want.mirror);
      end
    end
    if ($urandom_range(0, 63) == 0) stall_kind <= $urandom_range(0, 3);
    case (stall_kind)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ~out_ready_i;
    endcase
  end

  vector_row_t directed_rows[] = '{
    '{TOPO_ROW_A, 32'sd0, 1, 16'd0, 1'b0},
    '{TOPO_ROW_A, -32'sd1, 1, 16'd380, 1'b0},
    '{TOPO_ROW_A, 32'sd381, 1, 16'd0, 1'b0},
    '{TOPO_ROW_A, 32'sh7fffffff, 0, 16'd0, 1'b0},
    '{TOPO_ROW_A, 32'sh80000000, 0, 16'd0, 1'b0},
    '{TOPO_ROW_B, 32'sh55555555, 0, 16'd0, 1'b0},
    '{TOPO_PLAIN_A, 32'sd0, 1, 16'd0, 1'b0},
    '{TOPO_PLAIN_A, 32'sd1, 1, 16'd1, 1'b0},
    '{TOPO_PLAIN_A, 32'sd16383, 0, 16'd0, 1'b0},
    '{TOPO_PLAIN_A, 32'sd16384, 0, 16'd0, 1'b0},
    '{TOPO_PLAIN_A, 32'sh80000000, 0, 16'd0, 1'b0},
    '{TOPO_PLAIN_B, 32'sh7fffffff, 0, 16'd0, 1'b0},
    '{TOPO_HEX, 32'sh0001_8005, 0, 16'd0, 1'b0},
    '{TOPO_HEX, -32'sd98311, 0, 16'd0, 1'b0},
    '{TOPO_KLEIN_A, 32'sd12, 1, 16'd0, 1'b1},
    '{TOPO_KLEIN_A, 32'sh0000_8003, 0, 16'd0, 1'b0},
    '{TOPO_KLEIN_A, 32'sh0002_000f, 0, 16'd0, 1'b0},
    '{TOPO_KLEIN_HEX, 32'sd24, 0, 16'd0, 1'b0},
    '{TOPO_KLEIN_HEX, 32'sh0003_0019, 0, 16'd0, 1'b0},
    '{TOPO_KLEIN_HEX, -32'sd1, 0, 16'd0, 1'b0},
    '{TOPO_PLAIN_C, 32'sh1234_5678, 0, 16'd0, 1'b0},
    '{TOPO_PLAIN_D, 32'shfedc_ba98, 0, 16'd0, 1'b0},
    '{TOPO_KLEIN_B, -32'sd32780, 0, 16'd0, 1'b0},
    '{TOPO_KLEIN_C, 32'sh7fff_bfff, 0, 16'd0, 1'b0}
  };

  initial begin
    cell_result_t want;
    logic [15:0] count_val;
    logic [7:0]  w_val, h_val;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    packed_vector_i = '0;
    out_ready_i     = 1'b1;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_MODE;
    cfg_data_i      = '0;
    topo_mode  = RST_MODE;
    row_count  = RST_COUNT;
    grid_w     = RST_WIDTH;
    grid_h     = RST_HEIGHT;
    mismatches = 0;
    burst_left = 0;
    stall_kind = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != topo_mode) begin
        idle_sender();
        write_reg(CFG_MODE, {12'd0, directed_rows[i].mode});
      end
      want.idx    = directed_rows[i].idx;
      want.mirror = directed_rows[i].mirror;
      send_vector(directed_rows[i].vec, directed_rows[i].known, want);
    end

    // One phase per topology; the first few pin the register extremes
    for (int phase = 0; phase < 11; phase++) begin
      case (phase)
        0: begin count_val = 16'd1;     w_val = 8'd1;   h_val = 8'd255; end
        1: begin count_val = 16'hffff;  w_val = 8'd255; h_val = 8'd1;   end
        2: begin count_val = 16'd2;     w_val = 8'd255; h_val = 8'd255; end
        3: begin count_val = 16'd7;     w_val = 8'd1;   h_val = 8'd1;   end
        default: begin
          count_val = 16'($urandom_range(1, 65535));
          w_val     = 8'($urandom_range(1, 255));
          h_val     = 8'($urandom_range(1, 255));
        end
      endcase
      idle_sender();
      write_reg(CFG_MODE, 16'(phase));
      write_reg(CFG_COUNT, count_val);
      write_reg(CFG_WIDTH, {8'd0, w_val});
      write_reg(CFG_HEIGHT, {8'd0, h_val});
      for (int n = 0; n < 48; n++) begin
        want.idx    = '0;
        want.mirror = 1'b0;
        send_vector(random_vector(), 0, want);
      end
    end

    idle_sender();
    wait (pending_cells.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[quotient_grid_cell_index_top] OK");
    end else begin
      $display("[quotient_grid_cell_index_top] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[quotient_grid_cell_index_top] ERROR");
    $finish;
  end

endmodule
